[src/fit_pkg.sv]
// Shared constants and control types for the farthest-insertion tour block.
package fit_pkg;

    localparam int MAX_NODES = 64;
    localparam int DIST_BITS = 24;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int COST_W    = 30;
    localparam int SUM_W     = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;
    localparam int IC_W      = DIST_BITS + 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_NO_NODES  = 2'd2;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_START_NODE = 1'b1;

    typedef struct packed {
        logic take_in;
        logic init;
        logic sel_rd;
        logic sel_upd;
        logic ins_nx;
        logic ins_duc;
        logic ins_dcw;
        logic ins_duw;
        logic ins_cmp;
        logic link_a;
        logic link_b;
        logic cost_nx;
        logic cost_rd;
        logic cost_acc;
        logic emit_nx;
        logic emit_out;
        logic err_out;
    } fit_cmd_t;

    typedef struct packed {
        logic bad_n;
        logic bad_s;
        logic single;
        logic sel_end;
        logic first;
        logic full;
        logic w_head;
        logic out_fire;
        logic out_last;
    } fit_sts_t;

endpackage

[src/farthest_insertion_tour_top.sv]
// A matrix word is written to the store when it is taken; after the last word the build
// scans all nodes for the farthest one, then tries every tour edge, for each insertion.
// The cost walk visits each tour node once; then words leave one at a time, each after the last is taken.
// One build at a time; input stalls from the last word until the final result is taken.
// Reset is asynchronous active low: registers return to node_count 64, start 0, idle.
// Memories are not cleared; the user must write every entry a build reads beforehand, as the block does not check it.
module farthest_insertion_tour_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [23:0] distance,
    input  logic        last_entry,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  node,
    output logic [29:0] total_cost,
    output logic [1:0]  status,
    output logic        last
);
    import fit_pkg::*;

    fit_cmd_t cmd;
    fit_sts_t sts;

    fit_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_entry (last_entry),
        .sts        (sts),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    fit_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .row        (row),
        .col        (col),
        .distance   (distance),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .node       (node),
        .total_cost (total_cost),
        .status     (status),
        .last       (last)
    );

`ifndef ASSERT_OFF
    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input taken while a result word is pending");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> last)
        else $error("error word not marked last");

    a_cost_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (total_cost == '0))
        else $error("cost on a non-final word");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !in_stall)
        else $error("not idle after final word");
`endif

endmodule

[src/fit_ram.sv]
// Generic simple dual-port RAM with registered read.
module fit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/fit_ctrl.sv]
// Sequencer for load, build, cost and output phases.
module fit_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            last_entry,
    input  fit_pkg::fit_sts_t sts,
    output fit_pkg::fit_cmd_t cmd,
    output logic            in_stall
);
    import fit_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'b0000000000000000001,
        S_CHECK    = 19'b0000000000000000010,
        S_INIT     = 19'b0000000000000000100,
        S_SEL_RD   = 19'b0000000000000001000,
        S_SEL_UPD  = 19'b0000000000000010000,
        S_INS_NX   = 19'b0000000000000100000,
        S_INS_DUC  = 19'b0000000000001000000,
        S_INS_DCW  = 19'b0000000000010000000,
        S_INS_DUW  = 19'b0000000000100000000,
        S_INS_CMP  = 19'b0000000001000000000,
        S_LINK_A   = 19'b0000000010000000000,
        S_LINK_B   = 19'b0000000100000000000,
        S_COST_NX  = 19'b0000001000000000000,
        S_COST_RD  = 19'b0000010000000000000,
        S_COST_ACC = 19'b0000100000000000000,
        S_EMIT_NX  = 19'b0001000000000000000,
        S_EMIT_OUT = 19'b0010000000000000000,
        S_ERR_OUT  = 19'b0100000000000000000,
        S_OUT_WAIT = 19'b1000000000000000000
    } fit_state_t;

    fit_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid && last_entry) state_next = S_CHECK;
            S_CHECK:    state_next = (sts.bad_n || sts.bad_s) ? S_ERR_OUT : S_INIT;
            S_INIT:     state_next = sts.single ? S_COST_NX : S_SEL_RD;
            S_SEL_RD:   state_next = S_SEL_UPD;
            S_SEL_UPD:
            begin
                if (sts.sel_end)
                begin
                    state_next = sts.first ? S_LINK_A : S_INS_NX;
                end
                else
                begin
                    state_next = S_SEL_RD;
                end
            end
            S_INS_NX:   state_next = S_INS_DUC;
            S_INS_DUC:  state_next = S_INS_DCW;
            S_INS_DCW:  state_next = S_INS_DUW;
            S_INS_DUW:  state_next = S_INS_CMP;
            S_INS_CMP:  state_next = sts.w_head ? S_LINK_A : S_INS_NX;
            S_LINK_A:   state_next = S_LINK_B;
            S_LINK_B:   state_next = sts.full ? S_COST_NX : S_SEL_RD;
            S_COST_NX:  state_next = S_COST_RD;
            S_COST_RD:  state_next = S_COST_ACC;
            S_COST_ACC: state_next = sts.w_head ? S_EMIT_NX : S_COST_NX;
            S_EMIT_NX:  state_next = S_EMIT_OUT;
            S_EMIT_OUT: state_next = S_OUT_WAIT;
            S_ERR_OUT:  state_next = S_OUT_WAIT;
            S_OUT_WAIT:
            begin
                if (sts.out_fire)
                begin
                    state_next = sts.out_last ? S_IDLE : S_EMIT_NX;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.take_in  = (state_reg == S_IDLE) && in_valid;
    assign cmd.init     = (state_reg == S_INIT);
    assign cmd.sel_rd   = (state_reg == S_SEL_RD);
    assign cmd.sel_upd  = (state_reg == S_SEL_UPD);
    assign cmd.ins_nx   = (state_reg == S_INS_NX);
    assign cmd.ins_duc  = (state_reg == S_INS_DUC);
    assign cmd.ins_dcw  = (state_reg == S_INS_DCW);
    assign cmd.ins_duw  = (state_reg == S_INS_DUW);
    assign cmd.ins_cmp  = (state_reg == S_INS_CMP);
    assign cmd.link_a   = (state_reg == S_LINK_A);
    assign cmd.link_b   = (state_reg == S_LINK_B);
    assign cmd.cost_nx  = (state_reg == S_COST_NX);
    assign cmd.cost_rd  = (state_reg == S_COST_RD);
    assign cmd.cost_acc = (state_reg == S_COST_ACC);
    assign cmd.emit_nx  = (state_reg == S_EMIT_NX);
    assign cmd.emit_out = (state_reg == S_EMIT_OUT);
    assign cmd.err_out  = (state_reg == S_ERR_OUT);

endmodule

[src/fit_dp.sv]
// Datapath: distance store, nearest-tour distances, linked tour and result register.
module fit_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  fit_pkg::fit_cmd_t cmd,
    output fit_pkg::fit_sts_t sts,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic [5:0]        row,
    input  logic [5:0]        col,
    input  logic [23:0]       distance,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [5:0]        node,
    output logic [29:0]       total_cost,
    output logic [1:0]        status,
    output logic              last
);
    import fit_pkg::*;

    logic [6:0]            node_count_reg;
    logic [5:0]            start_node_reg;
    logic [NODE_W-1:0]     x_reg, v_reg, cand_reg, head_reg, u_reg, w_reg;
    logic [NODE_W-1:0]     bestu_reg, bestw_reg;
    logic                  first_reg, found_reg, have_reg;
    logic [CNT_W-1:0]      len_reg;
    logic [DIST_BITS-1:0]  best_min_reg, duc_reg, dcw_reg;
    logic signed [IC_W-1:0] best_ic_reg;
    logic [COST_W-1:0]     cost_reg;
    logic [MAX_NODES-1:0]  flag_reg;
    logic                  out_valid_reg, last_reg;
    logic [5:0]            node_reg;
    logic [COST_W-1:0]     tcost_reg;
    logic [1:0]            status_reg;

    logic                  dist_we;
    logic [ADDR_W-1:0]     dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0]  dist_rd, mind_rd, mval;
    logic                  nx_we;
    logic [NODE_W-1:0]     nx_waddr, nx_wdata, nx_rd;
    logic signed [IC_W-1:0] ic;
    logic [SUM_W-1:0]      csum;
    logic                  out_fire;

    assign dist_we    = cmd.take_in && (int'(row) < MAX_NODES) && (int'(col) < MAX_NODES);
    assign dist_waddr = {NODE_W'(row), NODE_W'(col)};

    always_comb
    begin
        dist_raddr = {u_reg, w_reg};
        if (cmd.sel_rd)
        begin
            dist_raddr = {x_reg, v_reg};
        end
        else if (cmd.ins_duc)
        begin
            dist_raddr = {u_reg, cand_reg};
        end
        else if (cmd.ins_dcw)
        begin
            dist_raddr = {cand_reg, w_reg};
        end
        else if (cmd.cost_rd)
        begin
            dist_raddr = {u_reg, nx_rd};
        end
    end

    fit_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (DIST_BITS'(distance)),
        .raddr (dist_raddr),
        .rdata (dist_rd)
    );

    // nearest tour distance of each node not yet in the tour, refreshed as each node joins
    assign mval = first_reg ? dist_rd : ((dist_rd < mind_rd) ? dist_rd : mind_rd);

    fit_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES)) u_mind (
        .clk   (clk),
        .we    (cmd.sel_upd && !flag_reg[v_reg]),
        .waddr (v_reg),
        .wdata (mval),
        .raddr (v_reg),
        .rdata (mind_rd)
    );

    // tour kept as a ring of successor pointers
    always_comb
    begin
        nx_we    = cmd.init || cmd.link_a || cmd.link_b;
        nx_waddr = bestu_reg;
        nx_wdata = cand_reg;
        if (cmd.init)
        begin
            nx_waddr = NODE_W'(start_node_reg);
            nx_wdata = NODE_W'(start_node_reg);
        end
        else if (cmd.link_a)
        begin
            nx_waddr = cand_reg;
            nx_wdata = bestw_reg;
        end
    end

    fit_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_next (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (u_reg),
        .rdata (nx_rd)
    );

    assign ic   = $signed(IC_W'(duc_reg)) + $signed(IC_W'(dcw_reg)) - $signed(IC_W'(dist_rd));
    assign csum = SUM_W'(cost_reg) + SUM_W'(dist_rd);
    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd64;
            start_node_reg <= 6'd0;
            out_valid_reg  <= 1'b0;
            flag_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NODE_COUNT)
                begin
                    node_count_reg <= cfg_data;
                end
                else
                begin
                    start_node_reg <= cfg_data[5:0];
                end
            end
            if (cmd.init)
            begin
                flag_reg <= MAX_NODES'(1) << start_node_reg;
            end
            else if (cmd.link_a)
            begin
                flag_reg[cand_reg] <= 1'b1;
            end
            if (cmd.emit_out || cmd.err_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            x_reg     <= NODE_W'(start_node_reg);
            head_reg  <= NODE_W'(start_node_reg);
            u_reg     <= NODE_W'(start_node_reg);
            bestu_reg <= NODE_W'(start_node_reg);
            bestw_reg <= NODE_W'(start_node_reg);
            first_reg <= 1'b1;
            len_reg   <= CNT_W'(1);
            v_reg     <= '0;
            found_reg <= 1'b0;
            cost_reg  <= '0;
        end
        if (cmd.sel_upd)
        begin
            if (!flag_reg[v_reg] && (!found_reg || mval > best_min_reg))
            begin
                found_reg    <= 1'b1;
                best_min_reg <= mval;
                cand_reg     <= v_reg;
            end
            v_reg    <= v_reg + 1'b1;
            have_reg <= 1'b0;
        end
        if (cmd.ins_duc)
        begin
            w_reg <= nx_rd;
        end
        if (cmd.ins_dcw)
        begin
            duc_reg <= dist_rd;
        end
        if (cmd.ins_duw)
        begin
            dcw_reg <= dist_rd;
        end
        if (cmd.ins_cmp)
        begin
            if (!have_reg || ic < best_ic_reg)
            begin
                have_reg    <= 1'b1;
                best_ic_reg <= ic;
                bestu_reg   <= u_reg;
                bestw_reg   <= w_reg;
            end
            u_reg <= w_reg;
        end
        if (cmd.link_a)
        begin
            len_reg <= len_reg + 1'b1;
            // insertion at the wrap point puts the new node at the front
            if (!first_reg && bestw_reg == head_reg)
            begin
                head_reg <= cand_reg;
            end
        end
        if (cmd.link_b)
        begin
            x_reg     <= cand_reg;
            first_reg <= 1'b0;
            u_reg     <= head_reg;
            v_reg     <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.cost_rd)
        begin
            w_reg <= nx_rd;
        end
        if (cmd.cost_acc)
        begin
            cost_reg <= (csum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(csum);
            u_reg    <= w_reg;
        end
        if (cmd.emit_out)
        begin
            node_reg   <= 6'(u_reg);
            last_reg   <= (nx_rd == head_reg);
            tcost_reg  <= (nx_rd == head_reg) ? cost_reg : '0;
            status_reg <= ST_OK;
            u_reg      <= nx_rd;
        end
        if (cmd.err_out)
        begin
            node_reg   <= '0;
            last_reg   <= 1'b1;
            tcost_reg  <= '0;
            status_reg <= sts.bad_n ? ST_NO_NODES : ST_BAD_START;
        end
    end

    assign sts.bad_n    = (node_count_reg == 7'd0) || (int'(node_count_reg) > MAX_NODES);
    assign sts.bad_s    = ({1'b0, start_node_reg} >= node_count_reg);
    assign sts.single   = (node_count_reg == 7'd1);
    assign sts.sel_end  = (int'(v_reg) + 1 == int'(node_count_reg));
    assign sts.first    = first_reg;
    assign sts.full     = (int'(len_reg) == int'(node_count_reg));
    assign sts.w_head   = (w_reg == head_reg);
    assign sts.out_fire = out_fire;
    assign sts.out_last = last_reg;

    assign out_valid  = out_valid_reg;
    assign node       = node_reg;
    assign total_cost = tcost_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the farthest-insertion tour builder.
module tb_top;
    import fit_pkg::*;

    typedef struct {
        logic [5:0]  node;
        logic [29:0] total_cost;
        logic [1:0]  status;
        logic        last;
    } tour_word_t;

    localparam int IDLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [23:0] distance;
    logic        last_entry;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  node;
    logic [29:0] total_cost;
    logic [1:0]  status;
    logic        last;

    // shadow of the block's registers and matrix store
    logic [23:0] dist_mem [0:4095];
    logic [6:0]  cur_count;
    logic [5:0]  cur_start;

    tour_word_t  tour_q [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          quiet_cycles;

    farthest_insertion_tour_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row        (row),
        .col        (col),
        .distance   (distance),
        .last_entry (last_entry),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .node       (node),
        .total_cost (total_cost),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [23:0] dist_at(int a, int b);
        return dist_mem[a * MAX_NODES + b];
    endfunction

    function automatic void push_error(logic [1:0] code);
        tour_word_t w;
        w.node = '0;
        w.total_cost = '0;
        w.status = code;
        w.last = 1'b1;
        tour_q = {tour_q, w};
    endfunction

    // stores the word and, on the final word, queues the whole tour it produces or the error word
    function automatic void predict_word(logic [5:0] r, logic [5:0] c, logic [23:0] d,
                                         logic fin);
        int          n;
        int          s;
        int          len;
        int          order [0:63];
        bit          in_tour [0:63];
        longint      best_min;
        longint      mn;
        longint      ic;
        longint      best_ins;
        longint      cost;
        int          cand;
        int          pos;
        int          nx;
        bit          found;
        tour_word_t  w;

        dist_mem[r * MAX_NODES + c] = d;
        if (!fin)
            return;
        n = int'(cur_count);
        s = int'(cur_start);
        if (n == 0 || n > MAX_NODES)
        begin
            push_error(ST_NO_NODES);
            return;
        end
        if (s >= n)
        begin
            push_error(ST_BAD_START);
            return;
        end
        foreach (in_tour[k])
            in_tour[k] = 1'b0;
        order[0] = s;
        in_tour[s] = 1'b1;
        len = 1;
        if (n >= 2)
        begin
            found = 1'b0;
            best_min = 0;
            cand = 0;
            for (int v = 0; v < n; v++)
            begin
                if (in_tour[v])
                    continue;
                if (!found || dist_at(s, v) > best_min)
                begin
                    found = 1'b1;
                    best_min = dist_at(s, v);
                    cand = v;
                end
            end
            order[len++] = cand;
            in_tour[cand] = 1'b1;
        end
        while (len < n)
        begin
            found = 1'b0;
            best_min = 0;
            cand = 0;
            for (int v = 0; v < n; v++)
            begin
                if (in_tour[v])
                    continue;
                mn = dist_at(order[0], v);
                for (int i = 1; i < len; i++)
                    if (dist_at(order[i], v) < mn)
                        mn = dist_at(order[i], v);
                if (!found || mn > best_min)
                begin
                    found = 1'b1;
                    best_min = mn;
                    cand = v;
                end
            end
            best_ins = 0;
            pos = 0;
            for (int i = 0; i < len; i++)
            begin
                nx = (i + 1 < len) ? i + 1 : 0;
                ic = longint'(dist_at(order[i], cand)) + longint'(dist_at(cand, order[nx]))
                     - longint'(dist_at(order[i], order[nx]));
                if (i == 0 || ic < best_ins)
                begin
                    best_ins = ic;
                    pos = nx;
                end
            end
            for (int i = len; i > pos; i--)
                order[i] = order[i - 1];
            order[pos] = cand;
            in_tour[cand] = 1'b1;
            len++;
        end
        cost = 0;
        for (int i = 0; i < len; i++)
        begin
            nx = (i + 1 < len) ? i + 1 : 0;
            cost += dist_at(order[i], order[nx]);
            if (cost > COST_MAX)
                cost = COST_MAX;
        end
        for (int i = 0; i < len; i++)
        begin
            w.node = 6'(order[i]);
            w.total_cost = (i + 1 == len) ? cost[29:0] : '0;
            w.status = ST_OK;
            w.last = (i + 1 == len);
            tour_q = {tour_q, w};
        end
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        tour_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tour_q.size() == 0)
            begin
                $error("unexpected tour word: node %0d", node);
                error_count++;
            end
            else
            begin
                w = tour_q.pop_front();
                if (node !== w.node)
                begin
                    $error("node: expected %0d, got %0d", w.node, node);
                    error_count++;
                end
                if (total_cost !== w.total_cost)
                begin
                    $error("total_cost: expected %0d, got %0d", w.total_cost, total_cost);
                    error_count++;
                end
                if (status !== w.status)
                begin
                    $error("status: expected %0d, got %0d", w.status, status);
                    error_count++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0d, got %0d", w.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_word(logic [5:0] r, logic [5:0] c, logic [23:0] d, logic fin);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        row        <= r;
        col        <= c;
        distance   <= d;
        last_entry <= fin;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(r, c, d, fin);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        wait (tour_q.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        go_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NODE_COUNT)
            cur_count = value;
        else
            cur_start = value[5:0];
    endtask

    function automatic logic [23:0] rand_dist(bit narrow);
        return narrow ? 24'($urandom_range(3)) : 24'($urandom);
    endfunction

    // full n x n matrix, final word starts the build
    task automatic send_matrix(int n, bit narrow);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_word(6'(r), 6'(c), rand_dist(narrow), (r == n - 1 && c == n - 1));
    endtask

    // fills the 8 x 8 corner of the store; every later build stays inside it
    task automatic test_full_matrix();
        write_reg(REG_NODE_COUNT, 7'd8);
        write_reg(REG_START_NODE, 7'd7);
        send_matrix(8, 1'b0);
        go_quiet();
        // near-maximum distances give the widest cost sums
        write_reg(REG_NODE_COUNT, 7'd8);
        write_reg(REG_START_NODE, 7'd0);
        for (int k = 0; k < 20; k++)
            send_word(6'($urandom_range(7)), 6'($urandom_range(7)),
                      24'(24'hFFFFFF - $urandom_range(3)), k == 19);
    endtask

    task automatic test_errors();
        write_reg(REG_NODE_COUNT, 7'd0);
        send_word(6'd63, 6'd0, 24'hFFFFFF, 1'b1);
        write_reg(REG_NODE_COUNT, 7'd127);
        send_word(6'd0, 6'd63, 24'd0, 1'b1);
        write_reg(REG_NODE_COUNT, 7'd65);
        send_word(6'd5, 6'd9, 24'h5A5A5A, 1'b1);
        write_reg(REG_NODE_COUNT, 7'd3);
        write_reg(REG_START_NODE, 7'd63);
        send_word(6'd1, 6'd2, 24'hA5A5A5, 1'b1);
        write_reg(REG_START_NODE, 7'd3);
        send_word(6'd2, 6'd1, 24'h000001, 1'b1);
    endtask

    task automatic test_single_node();
        write_reg(REG_NODE_COUNT, 7'd1);
        write_reg(REG_START_NODE, 7'd0);
        send_word(6'd0, 6'd0, 24'h123456, 1'b1);
        send_word(6'd0, 6'd0, 24'hFFFFFF, 1'b1);
    endtask

    task automatic random_build();
        int  n;
        int  pick;
        int  cnt;
        bit  narrow;
        pick = $urandom_range(99);
        n = (pick < 5) ? 1 : (pick < 8) ? 0 : (pick < 11) ? $urandom_range(65, 127)
          : (pick < 14) ? 8 : $urandom_range(2, 7);
        narrow = $urandom_range(1);
        write_reg(REG_NODE_COUNT, n[6:0]);
        write_reg(REG_START_NODE, ($urandom_range(99) < 8) ? 7'($urandom_range(63))
                                  : 7'($urandom_range((n >= 1 && n <= 64) ? n - 1 : 0)));
        // stray words anywhere in the store, possibly outside the tour's range
        if ($urandom_range(3) == 0)
            for (int k = $urandom_range(1, 3); k > 0; k--)
                send_word(6'($urandom_range(63)), 6'($urandom_range(63)),
                          rand_dist(narrow), 1'b0);
        if (n >= 1 && n <= 8 && $urandom_range(2) == 0)
            send_matrix(n, narrow);
        else
        begin
            cnt = $urandom_range(1, 10);
            for (int k = 0; k < cnt; k++)
                send_word(6'($urandom_range((n >= 1 && n <= 64) ? n - 1 : 63)),
                          6'($urandom_range((n >= 1 && n <= 64) ? n - 1 : 63)),
                          rand_dist(narrow), k == cnt - 1);
        end
    endtask

    task automatic test_random_builds();
        int sender_pct [4] = '{0, 46, 0, 8};
        int stall_pct [4]  = '{0, 0, 46, 8};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = sender_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int b = 0; b < 3; b++)
                random_build();
        end
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_NODE_COUNT, 7'd6);
        write_reg(REG_START_NODE, 7'd2);
        hold_cycles = 400;
        send_matrix(6, 1'b0);
        for (int k = 0; k < 5; k++)
            send_word(6'($urandom_range(5)), 6'($urandom_range(5)), rand_dist(1'b0), k == 4);
    endtask

    initial
    begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        cur_count      = 7'd64;
        cur_start      = 6'd0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_NODE_COUNT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        row            = '0;
        col            = '0;
        distance       = '0;
        last_entry     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_errors();
        test_single_node();
        test_full_matrix();
        test_random_builds();
        test_backpressure();

        in_valid <= 1'b0;
        wait (tour_q.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
